>>> rtl/wrsi_pkg.sv
// ----------------------------------------------------------------------------
// wrsi_pkg: shared types and constants of the windowed RSI block
// Command and status bundles between controller and datapath, field widths
// and fixed constants of the result format.
// ----------------------------------------------------------------------------
package wrsi_pkg;

    // Port widths fixed by the interface
    localparam int PRICE_W = 32;
    localparam int CFG_W   = 7;
    localparam int RSI_W   = 15;

    // Window length after reset (before clamping)
    localparam logic [CFG_W-1:0] CFG_RESET = 7'd30;

    // 100.0 with 8 fraction bits
    localparam logic [RSI_W-1:0] RSI_FULL = 15'd25600;

    // One quotient bit per divider step
    localparam int DIV_STEPS = RSI_W;
    localparam int DIV_CNT_W = $clog2(DIV_STEPS);

    // Controller to datapath
    typedef struct packed {
        logic accept;     // input transfer: latch change, read old ring entry
        logic cfg_write;  // configuration transfer: set length, clear window
        logic sub_old;    // drop the oldest change from the sums
        logic add_new;    // add new change, write ring, advance head
        logic mul1;       // total, partial product g*2^14 + g*2^13
        logic mul2;       // add g*2^10
        logic mul3;       // add rounding term total/2
        logic div_load;   // seed the divider
        logic div_step;   // one restoring step
        logic out_load;   // load the output register
    } wrsi_cmd_t;

    // Datapath to controller
    typedef struct packed {
        logic win_full;   // window holds window_length candles
        logic flat;       // both sums zero
    } wrsi_stat_t;

endpackage

>>> rtl/wrsi_ctrl.sv
// ----------------------------------------------------------------------------
// wrsi_ctrl: sequencing controller of the windowed RSI block
// Walks one candle through sum update, scaling and division, and owns the
// handshakes of all three channels.
// ----------------------------------------------------------------------------
module wrsi_ctrl (
    input  logic                  aclk,
    input  logic                  aresetn,
    input  logic                  cfg_valid,
    output logic                  cfg_ready,
    input  logic                  s_valid,
    output logic                  s_ready,
    output logic                  m_valid,
    input  logic                  m_ready,
    input  wrsi_pkg::wrsi_stat_t  stat,
    output wrsi_pkg::wrsi_cmd_t   cmd
);
    import wrsi_pkg::*;

    localparam logic [3:0] S_IDLE  = 4'd0;
    localparam logic [3:0] S_SUB   = 4'd1;
    localparam logic [3:0] S_ADD   = 4'd2;
    localparam logic [3:0] S_MUL1  = 4'd3;
    localparam logic [3:0] S_MUL2  = 4'd4;
    localparam logic [3:0] S_MUL3  = 4'd5;
    localparam logic [3:0] S_DLOAD = 4'd6;
    localparam logic [3:0] S_DIV   = 4'd7;
    localparam logic [3:0] S_DONE  = 4'd8;

    logic [3:0]           state_reg, state_next;
    logic [DIV_CNT_W-1:0] cnt_reg, cnt_next;
    logic                 m_valid_reg, m_valid_next;

    assign cfg_ready = (state_reg == S_IDLE);
    // Configuration takes precedence over a candle in the same cycle
    assign s_ready   = (state_reg == S_IDLE) && !cfg_valid;
    assign m_valid   = m_valid_reg;

    always_comb begin
        state_next = state_reg;
        cnt_next   = cnt_reg;
        cmd        = '0;
        cmd.cfg_write = cfg_valid && cfg_ready;
        cmd.accept    = s_valid && s_ready;
        unique case (state_reg)
            S_IDLE: begin
                if (cmd.accept) begin
                    state_next = S_SUB;
                end
            end
            S_SUB: begin
                cmd.sub_old = 1'b1;
                state_next  = S_ADD;
            end
            S_ADD: begin
                cmd.add_new = 1'b1;
                state_next  = S_MUL1;
            end
            S_MUL1: begin
                cmd.mul1   = 1'b1;
                state_next = stat.win_full ? S_MUL2 : S_DONE;
            end
            S_MUL2: begin
                cmd.mul2   = 1'b1;
                state_next = stat.flat ? S_DONE : S_MUL3;
            end
            S_MUL3: begin
                cmd.mul3   = 1'b1;
                state_next = S_DLOAD;
            end
            S_DLOAD: begin
                cmd.div_load = 1'b1;
                cnt_next     = '0;
                state_next   = S_DIV;
            end
            S_DIV: begin
                cmd.div_step = 1'b1;
                cnt_next     = cnt_reg + DIV_CNT_W'(1);
                if (cnt_reg == DIV_CNT_W'(DIV_STEPS - 1)) begin
                    state_next = S_DONE;
                end
            end
            S_DONE: begin
                // hold until the output register is free
                if (!m_valid_reg || m_ready) begin
                    cmd.out_load = 1'b1;
                    state_next   = S_IDLE;
                end
            end
            default: begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_comb begin
        m_valid_next = m_valid_reg;
        if (cmd.out_load) begin
            m_valid_next = 1'b1;
        end else if (m_ready) begin
            m_valid_next = 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg   <= S_IDLE;
            cnt_reg     <= '0;
            m_valid_reg <= 1'b0;
        end else begin
            state_reg   <= state_next;
            cnt_reg     <= cnt_next;
            m_valid_reg <= m_valid_next;
        end
    end

`ifndef NO_ASSERTIONS
    a_one_item: assert property (@(posedge aclk) disable iff (!aresetn)
        (s_valid && s_ready) |=> !s_ready)
        else $error("wrsi_ctrl: new candle taken while one is in progress");
    a_no_overwrite: assert property (@(posedge aclk) disable iff (!aresetn)
        cmd.out_load |-> (!m_valid_reg || m_ready))
        else $error("wrsi_ctrl: pending result overwritten");
    a_div_count: assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg == S_DIV) |-> (cnt_reg < DIV_CNT_W'(DIV_STEPS)))
        else $error("wrsi_ctrl: divider step count out of range");
`endif

endmodule

>>> rtl/wrsi_dp.sv
// ----------------------------------------------------------------------------
// wrsi_dp: datapath of the windowed RSI block
// Change ring memory, running gain and loss sums, shift-add scaling,
// restoring divider and output register.
// ----------------------------------------------------------------------------
module wrsi_dp #(
    parameter int MAX_WINDOW = 64,
    parameter int PRICE_BITS = 32
) (
    input  logic                          aclk,
    input  logic                          aresetn,
    input  wrsi_pkg::wrsi_cmd_t           cmd,
    output wrsi_pkg::wrsi_stat_t          stat,
    input  logic [wrsi_pkg::CFG_W-1:0]    cfg_window_length,
    input  logic [wrsi_pkg::PRICE_W-1:0]  s_open_tick,
    input  logic [wrsi_pkg::PRICE_W-1:0]  s_close_tick,
    output logic                          m_ready_res,
    output logic [wrsi_pkg::RSI_W-1:0]    m_rsi,
    output logic                          m_flat_window
);
    import wrsi_pkg::*;

    localparam int PB     = (PRICE_BITS < PRICE_W) ? PRICE_BITS : PRICE_W;
    localparam int RING_W = PB + 1;
    localparam int IDX_W  = $clog2(MAX_WINDOW);
    localparam int WL_W   = $clog2(MAX_WINDOW + 1);
    localparam int SUM_W  = PB + $clog2(MAX_WINDOW);
    localparam int NUM_W  = SUM_W + RSI_W;

    function automatic logic [WL_W-1:0] clamp_wl(input logic [CFG_W-1:0] v);
        logic [WL_W-1:0] r;
        if (v == '0) begin
            r = WL_W'(1);
        end else if (int'(v) > MAX_WINDOW) begin
            r = WL_W'(MAX_WINDOW);
        end else begin
            r = WL_W'(v);
        end
        return r;
    endfunction

    // Ring entry: {is_gain, magnitude}
    logic [RING_W-1:0] ring_mem [MAX_WINDOW];
    logic [RING_W-1:0] old_reg;
    logic [RING_W-1:0] chg_reg;

    logic [WL_W-1:0]  wl_reg;
    logic [WL_W-1:0]  fill_reg;
    logic [IDX_W-1:0] head_reg;
    logic [SUM_W-1:0] gain_reg;
    logic [SUM_W-1:0] loss_reg;
    logic             win_full_reg;
    logic             flat_reg;

    logic [SUM_W-1:0] total_reg;
    logic [NUM_W-1:0] acc_reg;
    logic [SUM_W-1:0] rem_reg;
    logic [RSI_W-1:0] num_low_reg;
    logic [RSI_W-1:0] quo_reg;

    logic             out_ready_reg;
    logic [RSI_W-1:0] out_rsi_reg;
    logic             out_flat_reg;

    // Change of the incoming candle
    logic [PB-1:0]     op, cp;
    logic              is_gain;
    logic [PB-1:0]     mag;
    logic [SUM_W-1:0]  old_ext, new_ext;
    logic [WL_W-1:0]   fill_inc;
    logic [SUM_W:0]    trial, tot_ext, diff;
    logic              ge;
    logic [RSI_W-1:0]  quo_sat;

    assign op      = s_open_tick[PB-1:0];
    assign cp      = s_close_tick[PB-1:0];
    assign is_gain = cp > op;
    assign mag     = is_gain ? (cp - op) : (op - cp);

    assign old_ext  = SUM_W'(old_reg[PB-1:0]);
    assign new_ext  = SUM_W'(chg_reg[PB-1:0]);
    assign fill_inc = (fill_reg < wl_reg) ? (fill_reg + WL_W'(1)) : fill_reg;

    assign trial   = {rem_reg, num_low_reg[RSI_W-1]};
    assign tot_ext = {1'b0, total_reg};
    assign ge      = trial >= tot_ext;
    assign diff    = trial - tot_ext;
    assign quo_sat = (quo_reg > RSI_FULL) ? RSI_FULL : quo_reg;

    assign stat.win_full = win_full_reg;
    assign stat.flat     = flat_reg;

    always_ff @(posedge aclk) begin
        if (cmd.add_new) begin
            ring_mem[head_reg] <= chg_reg;
        end
    end

    always_ff @(posedge aclk) begin
        if (cmd.accept) begin
            old_reg <= ring_mem[head_reg];
        end
    end

    // Window state
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wl_reg       <= clamp_wl(CFG_RESET);
            fill_reg     <= '0;
            head_reg     <= '0;
            gain_reg     <= '0;
            loss_reg     <= '0;
            win_full_reg <= 1'b0;
        end else if (cmd.cfg_write) begin
            wl_reg       <= clamp_wl(cfg_window_length);
            fill_reg     <= '0;
            head_reg     <= '0;
            gain_reg     <= '0;
            loss_reg     <= '0;
            win_full_reg <= 1'b0;
        end else if (cmd.sub_old) begin
            if (fill_reg >= wl_reg) begin
                if (old_reg[PB]) begin
                    gain_reg <= gain_reg - old_ext;
                end else begin
                    loss_reg <= loss_reg - old_ext;
                end
            end
        end else if (cmd.add_new) begin
            if (chg_reg[PB]) begin
                gain_reg <= gain_reg + new_ext;
            end else begin
                loss_reg <= loss_reg + new_ext;
            end
            if ((WL_W'(head_reg) + WL_W'(1)) >= wl_reg) begin
                head_reg <= '0;
            end else begin
                head_reg <= head_reg + IDX_W'(1);
            end
            fill_reg     <= fill_inc;
            win_full_reg <= (fill_inc == wl_reg);
        end
    end

    // Scaling and division: 25600 = 2^14 + 2^13 + 2^10
    always_ff @(posedge aclk) begin
        if (cmd.accept) begin
            chg_reg <= {is_gain, mag};
        end
        if (cmd.mul1) begin
            total_reg <= gain_reg + loss_reg;
            flat_reg  <= (gain_reg == '0) && (loss_reg == '0);
            acc_reg   <= (NUM_W'(gain_reg) << 14) + (NUM_W'(gain_reg) << 13);
        end
        if (cmd.mul2) begin
            acc_reg <= acc_reg + (NUM_W'(gain_reg) << 10);
        end
        if (cmd.mul3) begin
            acc_reg <= acc_reg + NUM_W'(total_reg >> 1);
        end
        if (cmd.div_load) begin
            rem_reg     <= acc_reg[NUM_W-1:RSI_W];
            num_low_reg <= acc_reg[RSI_W-1:0];
            quo_reg     <= '0;
        end
        if (cmd.div_step) begin
            rem_reg     <= ge ? diff[SUM_W-1:0] : trial[SUM_W-1:0];
            num_low_reg <= num_low_reg << 1;
            quo_reg     <= {quo_reg[RSI_W-2:0], ge};
        end
        if (cmd.out_load) begin
            out_ready_reg <= win_full_reg;
            out_flat_reg  <= win_full_reg && flat_reg;
            out_rsi_reg   <= (win_full_reg && !flat_reg) ? quo_sat : '0;
        end
    end

    assign m_ready_res   = out_ready_reg;
    assign m_rsi         = out_rsi_reg;
    assign m_flat_window = out_flat_reg;

`ifndef NO_ASSERTIONS
    a_rem_below_divisor: assert property (@(posedge aclk) disable iff (!aresetn)
        cmd.div_step |-> (rem_reg < total_reg))
        else $error("wrsi_dp: divider remainder not below divisor");
    a_window_bounds: assert property (@(posedge aclk) disable iff (!aresetn)
        (fill_reg <= wl_reg) && (WL_W'(head_reg) < wl_reg))
        else $error("wrsi_dp: fill count or head beyond window length");
    a_quo_bound: assert property (@(posedge aclk) disable iff (!aresetn)
        (cmd.out_load && win_full_reg && !flat_reg) |-> (quo_reg <= RSI_FULL))
        else $error("wrsi_dp: quotient above full scale");
`endif

endmodule

>>> rtl/windowed_relative_strength_index.sv
// ----------------------------------------------------------------------------
// windowed_relative_strength_index: moving-window RSI of candle data
// Keeps gain and loss sums over the last window_length candles and reports
// RSI = 100*G/(G+L) with 8 fraction bits, rounded to nearest.
// ----------------------------------------------------------------------------
// One candle is taken at a time. While the window is still filling, a candle
// goes from its input transfer through the sum update and the first scaling
// step straight to its result; once full but with both sums zero it also takes
// the second scaling step, and otherwise it goes on through rounding and the
// 15-step restoring divider in the datapath. The next candle can be taken at
// the same edge as that result transfer. The output register holds a finished
// result until its transfer, and the next candle is taken meanwhile. A result is
// issued for every candle: ready_res stays low until the window is full, a
// zero loss sum gives 100.0 and both sums zero give 0 with flat_window set.
// Writing window_length (clamped to 1..MAX_WINDOW) clears the window; the
// configuration port is ready only between candles.
// ----------------------------------------------------------------------------
module windowed_relative_strength_index #(
    parameter int MAX_WINDOW = 64,
    parameter int PRICE_BITS = 32
) (
    input  logic                          aclk,
    input  logic                          aresetn,
    // configuration write channel
    input  logic                          cfg_valid,
    output logic                          cfg_ready,
    input  logic [wrsi_pkg::CFG_W-1:0]    cfg_window_length,
    // candle input channel
    input  logic                          s_valid,
    output logic                          s_ready,
    input  logic [wrsi_pkg::PRICE_W-1:0]  s_open_tick,
    input  logic [wrsi_pkg::PRICE_W-1:0]  s_close_tick,
    // result channel
    output logic                          m_valid,
    input  logic                          m_ready,
    output logic                          m_ready_res,
    output logic [wrsi_pkg::RSI_W-1:0]    m_rsi,
    output logic                          m_flat_window
);
    import wrsi_pkg::*;

    wrsi_cmd_t  cmd;
    wrsi_stat_t stat;

    // Sequence each candle and own the handshakes
    wrsi_ctrl u_ctrl (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .s_valid   (s_valid),
        .s_ready   (s_ready),
        .m_valid   (m_valid),
        .m_ready   (m_ready),
        .stat      (stat),
        .cmd       (cmd)
    );

    // Ring, sums, divider and the output register
    wrsi_dp #(
        .MAX_WINDOW (MAX_WINDOW),
        .PRICE_BITS (PRICE_BITS)
    ) u_dp (
        .aclk              (aclk),
        .aresetn           (aresetn),
        .cmd               (cmd),
        .stat              (stat),
        .cfg_window_length (cfg_window_length),
        .s_open_tick       (s_open_tick),
        .s_close_tick      (s_close_tick),
        .m_ready_res       (m_ready_res),
        .m_rsi             (m_rsi),
        .m_flat_window     (m_flat_window)
    );

endmodule

>>> bench/testbench.sv
// ----------------------------------------------------------------------------
// testbench: self-checking bench for windowed_relative_strength_index
// Feeds candles through the valid/ready input channel and compares every
// result field with a cycle-free model of the moving RSI window. The window
// length is rewritten between batches, including its clamped extremes.
// ----------------------------------------------------------------------------
module testbench;

    timeunit 1ns;
    timeprecision 1ps;

    import wrsi_pkg::*;

    localparam int WINDOW_DEPTH = 64;
    localparam int CYCLE_LIMIT  = 400000;
    localparam int TAIL_CYCLES  = 40;
    localparam int REPORT_MAX   = 10;

    typedef struct packed {
        logic [PRICE_W-1:0] open_tick;
        logic [PRICE_W-1:0] close_tick;
    } candle_t;

    typedef struct packed {
        logic             ready_res;
        logic [RSI_W-1:0] rsi;
        logic             flat_window;
    } rsi_result_t;

    // Market behaviour of one random stretch of candles
    typedef enum {
        MARKET_FLAT, MARKET_RISING, MARKET_FALLING, MARKET_CHOPPY,
        MARKET_WILD, MARKET_EXTREME
    } market_t;

    localparam logic [PRICE_W-1:0] PRICE_MAX = '1;

    // Clock, reset and DUT ports; every input starts at a known value
    logic                 aclk              = 1'b0;
    logic                 aresetn           = 1'b0;
    logic                 cfg_valid         = 1'b0;
    logic                 cfg_ready;
    logic [CFG_W-1:0]     cfg_window_length = CFG_RESET;
    logic                 s_valid           = 1'b0;
    logic                 s_ready;
    logic [PRICE_W-1:0]   s_open_tick       = '0;
    logic [PRICE_W-1:0]   s_close_tick      = '0;
    logic                 m_valid;
    logic                 m_ready           = 1'b0;
    logic                 m_ready_res;
    logic [RSI_W-1:0]     m_rsi;
    logic                 m_flat_window;

    // Model of the window: ring of signed changes and the two running sums
    logic signed [PRICE_W:0] change_ring [0:WINDOW_DEPTH-1];
    logic [5:0]              ring_head;
    logic [6:0]              fill_count;
    logic [37:0]             gain_sum;
    logic [37:0]             loss_sum;
    logic [6:0]              window_len;

    candle_t     candle_q[$];     // candles waiting for the driver
    rsi_result_t pending_rsi[$];  // predicted results, oldest first

    logic        idle_on     = 1'b1;
    int unsigned src_gap     = 0;
    int unsigned sink_stall  = 0;
    int unsigned cycle_count = 0;
    int unsigned mismatches  = 0;
    int unsigned candles_in  = 0;
    int unsigned checked     = 0;
    int unsigned full_seen   = 0;
    int unsigned flat_seen   = 0;
    int unsigned top_seen    = 0;
    int unsigned length_writes = 0;

    windowed_relative_strength_index dut (
        .aclk              (aclk),
        .aresetn           (aresetn),
        .cfg_valid         (cfg_valid),
        .cfg_ready         (cfg_ready),
        .cfg_window_length (cfg_window_length),
        .s_valid           (s_valid),
        .s_ready           (s_ready),
        .s_open_tick       (s_open_tick),
        .s_close_tick      (s_close_tick),
        .m_valid           (m_valid),
        .m_ready           (m_ready),
        .m_ready_res       (m_ready_res),
        .m_rsi             (m_rsi),
        .m_flat_window     (m_flat_window)
    );

    initial begin
        forever #4 aclk = ~aclk;
    end

    // Clamp the length to 1..64 and empty the window, as a register write does
    function automatic void restart_window(input logic [CFG_W-1:0] len);
        if (len == 0) begin
            window_len = 7'd1;
        end else if (len > WINDOW_DEPTH) begin
            window_len = 7'(WINDOW_DEPTH);
        end else begin
            window_len = len;
        end
        ring_head  = '0;
        fill_count = '0;
        gain_sum   = '0;
        loss_sum   = '0;
    endfunction

    // Take one candle into the window and work out the result it causes
    function automatic rsi_result_t advance_window(input logic [PRICE_W-1:0] op,
                                                   input logic [PRICE_W-1:0] cp);
        logic signed [PRICE_W:0] change;
        logic signed [PRICE_W:0] oldest;
        logic [6:0]              next_head;
        logic [63:0]             total;
        rsi_result_t             res;
        change = $signed({1'b0, cp}) - $signed({1'b0, op});
        res    = '0;
        // Drop the change that falls out of a full window
        if (fill_count >= window_len) begin
            oldest = change_ring[ring_head];
            if (oldest > 0) begin
                gain_sum = gain_sum - 38'(oldest);
            end else begin
                loss_sum = loss_sum - 38'(-oldest);
            end
        end
        change_ring[ring_head] = change;
        if (change > 0) begin
            gain_sum = gain_sum + 38'(change);
        end else begin
            loss_sum = loss_sum + 38'(-change);
        end
        next_head = {1'b0, ring_head} + 7'd1;
        if (next_head >= window_len) begin
            next_head = '0;
        end
        ring_head = next_head[5:0];
        if (fill_count < window_len) begin
            fill_count = fill_count + 7'd1;
        end
        if (fill_count == window_len) begin
            res.ready_res = 1'b1;
            total = {26'd0, gain_sum} + {26'd0, loss_sum};
            if (total == 0) begin
                res.flat_window = 1'b1;
            end else begin
                // Round to nearest, ties upward
                res.rsi = RSI_W'(({26'd0, gain_sum} * 64'(RSI_FULL) + (total >> 1))
                                 / total);
            end
        end
        return res;
    endfunction

    // Driver: present queued candles, predict on each transfer, idle in bursts
    always @(posedge aclk) begin
        if (!aresetn) begin
            s_valid <= 1'b0;
            src_gap <= 0;
        end else begin
            if (s_valid && s_ready) begin
                pending_rsi.insert(pending_rsi.size(),
                                   advance_window(s_open_tick, s_close_tick));
                candles_in++;
            end
            if (!s_valid || s_ready) begin
                if (idle_on && src_gap != 0) begin
                    src_gap <= src_gap - 1;
                    s_valid <= 1'b0;
                end else if (candle_q.size() != 0) begin
                    s_valid      <= 1'b1;
                    s_open_tick  <= candle_q[0].open_tick;
                    s_close_tick <= candle_q[0].close_tick;
                    candle_q.delete(0);
                    // Hold off the following candle for a random burst
                    if (idle_on && $urandom_range(0, 3) == 0) begin
                        src_gap <= $urandom_range(1, 15);
                    end
                end else begin
                    s_valid <= 1'b0;
                end
            end
        end
    end

    // Monitor: check each result transfer against the oldest prediction and
    // stall the result channel in random bursts
    always @(posedge aclk) begin
        rsi_result_t want;
        if (!aresetn) begin
            m_ready    <= 1'b0;
            sink_stall <= 0;
        end else begin
            if (m_valid && m_ready) begin
                if (pending_rsi.size() == 0) begin
                    if (mismatches < REPORT_MAX) begin
                        $display("[%0t] unexpected result: ready_res=%0b rsi=%0d flat=%0b",
                                 $realtime, m_ready_res, m_rsi, m_flat_window);
                    end
                    mismatches++;
                end else begin
                    want = pending_rsi[0];
                    pending_rsi.delete(0);
                    checked++;
                    if (m_ready_res !== want.ready_res || m_rsi !== want.rsi ||
                        m_flat_window !== want.flat_window) begin
                        if (mismatches < REPORT_MAX) begin
                            $display({"[%0t] result %0d: expected ready_res=%0b rsi=%0d",
                                      " flat=%0b, got ready_res=%0b rsi=%0d flat=%0b"},
                                     $realtime, checked, want.ready_res, want.rsi,
                                     want.flat_window, m_ready_res, m_rsi, m_flat_window);
                        end
                        mismatches++;
                    end
                    if (want.ready_res) full_seen++;
                    if (want.flat_window) flat_seen++;
                    if (want.rsi == RSI_FULL) top_seen++;
                end
            end
            if (idle_on && sink_stall != 0) begin
                sink_stall <= sink_stall - 1;
                m_ready    <= 1'b0;
            end else if (idle_on && $urandom_range(0, 7) == 0) begin
                sink_stall <= $urandom_range(0, 14);
                m_ready    <= 1'b0;
            end else begin
                m_ready <= 1'b1;
            end
        end
    end

    // Watchdog: stop a run that has hung
    always @(posedge aclk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count == CYCLE_LIMIT) begin
            $display("run stopped after %0d cycles with %0d results outstanding",
                     CYCLE_LIMIT, pending_rsi.size());
            $display("SCOREBOARD MISMATCH");
            $finish;
        end
    end

    task automatic queue_candle(input logic [PRICE_W-1:0] op,
                                input logic [PRICE_W-1:0] cp);
        candle_t item;
        item.open_tick  = op;
        item.close_tick = cp;
        candle_q.insert(candle_q.size(), item);
    endtask

    // Wait until every candle has gone in and every result has come out
    task automatic settle();
        do @(negedge aclk);
        while (candle_q.size() != 0 || s_valid || pending_rsi.size() != 0);
    endtask

    // Write window_length while idle; the model restarts on the transfer
    task automatic write_window_length(input logic [CFG_W-1:0] len);
        @(posedge aclk);
        cfg_valid         <= 1'b1;
        cfg_window_length <= len;
        do @(posedge aclk);
        while (!cfg_ready);
        restart_window(len);
        length_writes++;
        cfg_valid <= 1'b0;
        @(negedge aclk);
    endtask

    initial begin
        logic [CFG_W-1:0]   lengths [0:11];
        logic [PRICE_W-1:0] base;
        logic [PRICE_W-1:0] op;
        logic [PRICE_W-1:0] cp;
        logic [11:0]        step;
        market_t            market;
        int                 left;
        int                 run;

        lengths = '{7'd127, 7'd1, 7'd64, 7'd30, 7'd65, 7'd5,
                    7'd0, 7'd17, 7'd100, 7'd2, 7'd0, 7'd0};
        lengths[10] = 7'($urandom_range(0, 127));
        lengths[11] = 7'($urandom_range(0, 127));

        restart_window(CFG_RESET);
        repeat (5) @(posedge aclk);
        aresetn <= 1'b1;
        @(negedge aclk);

        // Reset length of 30: the window stays short of full
        queue_candle('0, '0);
        queue_candle(PRICE_MAX, '0);
        queue_candle('0, PRICE_MAX);
        settle();

        // Length zero clamps to one: every candle fills the window alone
        write_window_length(7'd0);
        queue_candle('0, PRICE_MAX);              // largest gain, no loss
        queue_candle(PRICE_MAX, '0);              // largest loss, no gain
        queue_candle(32'd7, 32'd7);               // flat
        queue_candle(PRICE_MAX, PRICE_MAX);       // flat at the top price
        queue_candle(32'd100, 32'd101);
        queue_candle(32'hAAAA_AAAA, 32'h5555_5555);
        queue_candle(32'h5555_5555, 32'hAAAA_AAAA);
        settle();

        // Two candles: even split, loss only, flat, and a rounding tie
        write_window_length(7'd2);
        queue_candle('0, PRICE_MAX);
        queue_candle(PRICE_MAX, '0);              // gain and loss equal
        queue_candle('0, '0);                     // loss only
        queue_candle('0, '0);                     // both sums zero
        queue_candle(32'd0, 32'd1);
        queue_candle(32'd2, 32'd1);
        queue_candle(32'd0, 32'd1);
        queue_candle(32'd2047, 32'd0);            // 12.5 rounds up to 13
        settle();

        // Random batches, one per window length; the last two, and those at positions 2, 5 and 8, run unthrottled
        foreach (lengths[p]) begin
            write_window_length(lengths[p]);
            idle_on = (p < 10) && (p % 3 != 2);
            left = 128;
            while (left > 0) begin
                market = market_t'($urandom_range(0, 5));
                run    = $urandom_range(1, 80);
                if (run > left) run = left;
                left -= run;
                repeat (run) begin
                    base = $urandom_range(0, 32'hFFFF_F000);
                    step = 12'($urandom_range(1, 4095));
                    case (market)
                        MARKET_FLAT: begin
                            op = $urandom;
                            cp = op;
                        end
                        MARKET_RISING: begin
                            op = base;
                            cp = base + step;
                        end
                        MARKET_FALLING: begin
                            op = base + step;
                            cp = base;
                        end
                        MARKET_CHOPPY: begin
                            op = base + $urandom_range(0, 4095);
                            cp = base + $urandom_range(0, 4095);
                        end
                        MARKET_WILD: begin
                            op = $urandom;
                            cp = $urandom;
                        end
                        default: begin
                            op = $urandom_range(0, 1) ? PRICE_MAX : '0;
                            cp = $urandom_range(0, 2) == 0 ? $urandom
                               : ($urandom_range(0, 1) ? PRICE_MAX : '0);
                        end
                    endcase
                    queue_candle(op, cp);
                end
            end
            settle();
        end

        // Let any stray result show up before judging
        repeat (TAIL_CYCLES) @(posedge aclk);
        if (pending_rsi.size() != 0) begin
            $display("%0d predicted results never arrived", pending_rsi.size());
        end

        $display("%0d candles over %0d window length writes, %0d results checked",
                 candles_in, length_writes, checked);
        $display("%0d full windows, %0d flat windows, %0d at the 100.0 ceiling",
                 full_seen, flat_seen, top_seen);
        if (mismatches == 0 && pending_rsi.size() == 0) begin
            $display("SCOREBOARD CLEAN");
        end else begin
            $display("SCOREBOARD MISMATCH");
        end
        $finish;
    end

endmodule
